@@ hw/rtl/slu_pkg.sv @@
// Shared types, codes and character-class helpers for the query lexer.
package slu_pkg;

    localparam int QDEPTH     = 4;
    localparam int HOLD_DEPTH = 6;

    localparam logic [2:0] K_KEYWORD  = 3'd0;
    localparam logic [2:0] K_IDENT    = 3'd1;
    localparam logic [2:0] K_LITERAL  = 3'd2;
    localparam logic [2:0] K_OPERATOR = 3'd3;
    localparam logic [2:0] K_UNKNOWN  = 3'd4;
    localparam logic [2:0] K_EOF      = 3'd5;

    localparam logic       REQ_BYTE = 1'b0;
    localparam logic       REQ_END  = 1'b1;

    localparam logic [47:0] KW_SELECT = "SELECT";
    localparam logic [39:0] KW_WHERE  = "WHERE";
    localparam logic [31:0] KW_FROM   = "FROM";

    // One result item.
    typedef struct packed {
        logic       is_end;
        logic [7:0] val;
        logic [2:0] kind;
    } t_res;

    // Results of one request: held bytes first, then up to three plain results.
    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] hold;
        logic [2:0]                 flush_n;
        logic [2:0]                 flush_kind;
        logic [1:0]                 simple_n;
        t_res [2:0]                 simple;
    } t_cmd;

    function automatic t_res mk_res(logic e, logic [7:0] v, logic [2:0] k);
        t_res r;
        r.is_end = e;
        r.val    = v;
        r.kind   = k;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_lead(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

endpackage

@@ hw/rtl/slu_front.sv @@
// Front end: classifies each request byte and builds the result command.
module slu_front import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_IDENT = 3'd1,
        M_NUM   = 3'd2,
        M_STR   = 3'd3,
        M_OP    = 3'd4
    } t_mode;

    localparam logic [2:0] STREAMING = 3'd7;

    t_mode                      r_mode, n_mode;
    logic                       r_qdbl, n_qdbl;
    logic [HOLD_DEPTH-1:0][7:0] r_hold, n_hold;
    logic [2:0]                 r_count, n_count;

    logic       accept;
    logic [1:0] sn;
    logic       do_start;
    logic       kw;
    logic [2:0] ckind;
    logic [HOLD_DEPTH-1:0][7:0] up;
    logic [7:0] b;
    logic [7:0] quote;
    t_cmd       cmd;

    assign b       = i_byte;
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            up[i] = to_upper(r_hold[i]);
        end
        kw = (r_count == 3'd6 && {up[0], up[1], up[2], up[3], up[4], up[5]} == KW_SELECT)
          || (r_count == 3'd4 && {up[0], up[1], up[2], up[3]} == KW_FROM)
          || (r_count == 3'd5 && {up[0], up[1], up[2], up[3], up[4]} == KW_WHERE);
        ckind = kw ? K_KEYWORD : K_IDENT;
        quote = r_qdbl ? 8'h22 : 8'h27;
    end

    always_comb begin
        n_mode   = r_mode;
        n_qdbl   = r_qdbl;
        n_hold   = r_hold;
        n_count  = r_count;
        cmd      = '0;
        cmd.hold = kw ? up : r_hold;
        sn       = 2'd0;
        do_start = 1'b0;

        if (i_req_type == REQ_END) begin
            case (r_mode)
                M_IDENT: begin
                    if (r_count <= 3'd6) begin
                        cmd.flush_n    = r_count;
                        cmd.flush_kind = ckind;
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, ckind);
                    end else begin
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_IDENT);
                    end
                    sn = sn + 2'd1;
                end
                M_NUM, M_STR: begin
                    cmd.simple[sn] = mk_res(1'b1, 8'd0, K_LITERAL);
                    sn = sn + 2'd1;
                end
                M_OP: begin
                    cmd.simple[sn] = mk_res(1'b1, 8'd0, K_OPERATOR);
                    sn = sn + 2'd1;
                end
                default: ;
            endcase
            cmd.simple[sn] = mk_res(1'b1, 8'd0, K_EOF);
            sn = sn + 2'd1;
            n_mode  = M_IDLE;
            n_count = 3'd0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_lead(b) || is_digit(b)) begin
                        if (r_count < 3'd6) begin
                            n_hold[r_count] = b;
                            n_count = r_count + 3'd1;
                        end else if (r_count == 3'd6) begin
                            cmd.hold       = r_hold;
                            cmd.flush_n    = 3'd6;
                            cmd.flush_kind = K_IDENT;
                            cmd.simple[sn] = mk_res(1'b0, b, K_IDENT);
                            sn = sn + 2'd1;
                            n_count = STREAMING;
                        end else begin
                            cmd.simple[sn] = mk_res(1'b0, b, K_IDENT);
                            sn = sn + 2'd1;
                        end
                    end else begin
                        // close the identifier, then lex this byte afresh
                        if (r_count <= 3'd6) begin
                            cmd.flush_n    = r_count;
                            cmd.flush_kind = ckind;
                            cmd.simple[sn] = mk_res(1'b1, 8'd0, ckind);
                        end else begin
                            cmd.simple[sn] = mk_res(1'b1, 8'd0, K_IDENT);
                        end
                        sn = sn + 2'd1;
                        n_count  = 3'd0;
                        do_start = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(b)) begin
                        cmd.simple[sn] = mk_res(1'b0, b, K_LITERAL);
                        sn = sn + 2'd1;
                    end else begin
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_LITERAL);
                        sn = sn + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == quote) begin
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_LITERAL);
                        sn = sn + 2'd1;
                        n_mode = M_IDLE;
                    end else if (b == 8'd0) begin
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_LITERAL);
                        sn = sn + 2'd1;
                        do_start = 1'b1;
                    end else begin
                        cmd.simple[sn] = mk_res(1'b0, b, K_LITERAL);
                        sn = sn + 2'd1;
                    end
                end
                M_OP: begin
                    if (b == "=") begin
                        cmd.simple[sn] = mk_res(1'b0, b, K_OPERATOR);
                        sn = sn + 2'd1;
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_OPERATOR);
                        sn = sn + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        cmd.simple[sn] = mk_res(1'b1, 8'd0, K_OPERATOR);
                        sn = sn + 2'd1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            if (do_start) begin
                n_mode = M_IDLE;
                if (is_space(b)) begin
                    n_mode = M_IDLE;
                end else if (is_lead(b)) begin
                    n_mode    = M_IDENT;
                    n_hold[0] = b;
                    n_count   = 3'd1;
                end else if (is_digit(b)) begin
                    n_mode = M_NUM;
                    cmd.simple[sn] = mk_res(1'b0, b, K_LITERAL);
                    sn = sn + 2'd1;
                end else if (b == 8'h27 || b == 8'h22) begin
                    n_mode = M_STR;
                    n_qdbl = (b == 8'h22);
                end else if (b == "=" || b == "<" || b == ">") begin
                    n_mode = M_OP;
                    cmd.simple[sn] = mk_res(1'b0, b, K_OPERATOR);
                    sn = sn + 2'd1;
                end else if (b == "*") begin
                    cmd.simple[sn] = mk_res(1'b0, b, K_IDENT);
                    sn = sn + 2'd1;
                    cmd.simple[sn] = mk_res(1'b1, 8'd0, K_IDENT);
                    sn = sn + 2'd1;
                end else begin
                    cmd.simple[sn] = mk_res(1'b0, b, K_UNKNOWN);
                    sn = sn + 2'd1;
                    cmd.simple[sn] = mk_res(1'b1, 8'd0, K_UNKNOWN);
                    sn = sn + 2'd1;
                end
            end
        end
        cmd.simple_n = sn;
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.flush_n != 3'd0 || cmd.simple_n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_qdbl  <= 1'b0;
            r_count <= 3'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_qdbl  <= n_qdbl;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= n_hold;
        end
    end

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != M_IDENT |-> r_count == 3'd0)
        else $error("hold count left over outside an identifier");
    a_count_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_IDENT |-> r_count != 3'd0)
        else $error("identifier open with nothing held");

endmodule

@@ hw/rtl/slu_cmd_queue.sv @@
// Short command queue between the classifier and the result sequencer.
module slu_cmd_queue import slu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd            r_mem [QDEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full command queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty command queue");

endmodule

@@ hw/rtl/slu_back.sv @@
// Back end: walks each command one result per cycle into the output register while the output is not stalled.
module slu_back import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res,
    output logic       o_last
);

    logic [3:0] r_idx;
    logic       r_valid;
    t_res       r_res;
    logic       r_last;

    logic [3:0] total;
    logic [3:0] sidx;
    logic       load;
    logic       is_last;
    t_res       cur;

    assign total   = {1'b0, i_cmd.flush_n} + {2'b00, i_cmd.simple_n};
    assign sidx    = r_idx - {1'b0, i_cmd.flush_n};
    assign is_last = (r_idx == total - 4'd1);
    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_pop   = load && is_last;

    always_comb begin
        if (r_idx < {1'b0, i_cmd.flush_n}) begin
            cur = mk_res(1'b0, i_cmd.hold[r_idx[2:0]], i_cmd.flush_kind);
        end else begin
            cur = i_cmd.simple[sidx[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur;
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx < total)
        else $error("result index past end of command");
    a_idx_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 4'd0 |-> i_q_valid)
        else $error("command left the queue mid-walk");

endmodule

@@ hw/rtl/sql_query_lexer_unit.sv @@
// Top level of the query lexer: classifier, command queue and result sequencer.
// Takes one query byte (or an end-of-input request) per cycle while the command
// queue is not full and produces the token stream one result per cycle while the
// receiver is ready; each request causes 0 to 9 results, which leave through the
// result sequencer's single output port. A four-entry command queue lets byte
// intake run ahead of the result drain, and requests that cause no result
// (whitespace, held identifier bytes) never enter the queue.
module sql_query_lexer_unit import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tuser,   // req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // value_byte
    output logic [3:0] m_axis_tuser,   // is_token_end, token_kind[2:0]
    output logic       m_axis_tlast    // last_in_run
);

    logic q_full, q_valid, push, pop;
    t_cmd front_cmd, head_cmd;
    t_res res;

    slu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    slu_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    slu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = res.val;
    assign m_axis_tuser = {res.kind, res.is_end};

endmodule

@@ tb/slu_token_checker.sv @@
// Token-stream checker for the query lexer: predicts results per request and compares.
module slu_token_checker import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_req,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [3:0] i_out_user,   // is_token_end, token_kind[2:0]
    input  logic       i_out_last,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         WORD_STREAM = 7;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_NUL      = 8'h00;

    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_WORD = 3'd1,
        LX_NUM  = 3'd2,
        LX_STR  = 3'd3,
        LX_OP   = 3'd4
    } t_lex_mode;

    typedef struct packed {
        logic       is_end;
        logic [7:0] val;
        logic [2:0] kind;
        logic       last;
    } t_lex_res;

    t_lex_mode  mode;
    logic       dq_open;
    logic [7:0] word_buf [HOLD_DEPTH];
    int         word_n;

    t_lex_res   step_res [0:9];
    int         step_n;
    t_lex_res   token_q [$];
    int         errs;
    int         checked;

    function automatic bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha_(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    // Keyword lengths are all distinct, so the held count picks the candidate.
    function automatic bit keyword_held();
        string w;
        if (word_n == 6) w = "SELECT";
        else if (word_n == 5) w = "WHERE";
        else if (word_n == 4) w = "FROM";
        else return 1'b0;
        for (int i = 0; i < word_n; i++)
            if (upcase(word_buf[i]) != w[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic put(input logic e, input logic [7:0] v, input logic [2:0] k);
        step_res[step_n].is_end = e;
        step_res[step_n].val    = v;
        step_res[step_n].kind   = k;
        step_res[step_n].last   = 1'b0;
        step_n++;
    endtask

    task automatic close_word();
        bit         kw;
        logic [2:0] k;
        if (word_n <= HOLD_DEPTH) begin
            kw = keyword_held();
            k  = kw ? K_KEYWORD : K_IDENT;
            for (int i = 0; i < word_n; i++)
                put(1'b0, kw ? upcase(word_buf[i]) : word_buf[i], k);
            put(1'b1, 8'h00, k);
        end else begin
            put(1'b1, 8'h00, K_IDENT);
        end
        word_n = 0;
        mode   = LX_IDLE;
    endtask

    task automatic open_token(input logic [7:0] b);
        mode = LX_IDLE;
        if (is_blank(b)) begin
        end else if (is_alpha_(b)) begin
            mode        = LX_WORD;
            word_buf[0] = b;
            word_n      = 1;
        end else if (is_num(b)) begin
            mode = LX_NUM;
            put(1'b0, b, K_LITERAL);
        end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
            mode    = LX_STR;
            dq_open = (b == CH_DQUOTE);
        end else if (b == "=" || b == "<" || b == ">") begin
            mode = LX_OP;
            put(1'b0, b, K_OPERATOR);
        end else if (b == "*") begin
            put(1'b0, b, K_IDENT);
            put(1'b1, 8'h00, K_IDENT);
        end else begin
            put(1'b0, b, K_UNKNOWN);
            put(1'b1, 8'h00, K_UNKNOWN);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b);
        case (mode)
            LX_WORD: begin
                if (is_alpha_(b) || is_num(b)) begin
                    if (word_n < HOLD_DEPTH) begin
                        word_buf[word_n] = b;
                        word_n++;
                    end else if (word_n == HOLD_DEPTH) begin
                        // seventh byte: too long for a keyword, release the hold
                        for (int i = 0; i < HOLD_DEPTH; i++)
                            put(1'b0, word_buf[i], K_IDENT);
                        put(1'b0, b, K_IDENT);
                        word_n = WORD_STREAM;
                    end else begin
                        put(1'b0, b, K_IDENT);
                    end
                end else begin
                    close_word();
                    open_token(b);
                end
            end
            LX_NUM: begin
                if (is_num(b)) begin
                    put(1'b0, b, K_LITERAL);
                end else begin
                    put(1'b1, 8'h00, K_LITERAL);
                    open_token(b);
                end
            end
            LX_STR: begin
                if (b == (dq_open ? CH_DQUOTE : CH_SQUOTE)) begin
                    put(1'b1, 8'h00, K_LITERAL);
                    mode = LX_IDLE;
                end else if (b == CH_NUL) begin
                    put(1'b1, 8'h00, K_LITERAL);
                    open_token(b);
                end else begin
                    put(1'b0, b, K_LITERAL);
                end
            end
            LX_OP: begin
                if (b == "=") begin
                    put(1'b0, b, K_OPERATOR);
                    put(1'b1, 8'h00, K_OPERATOR);
                    mode = LX_IDLE;
                end else begin
                    put(1'b1, 8'h00, K_OPERATOR);
                    open_token(b);
                end
            end
            default: open_token(b);
        endcase
    endtask

    task automatic lex_end();
        case (mode)
            LX_WORD:        close_word();
            LX_NUM, LX_STR: put(1'b1, 8'h00, K_LITERAL);
            LX_OP:          put(1'b1, 8'h00, K_OPERATOR);
            default: ;
        endcase
        put(1'b1, 8'h00, K_EOF);
        mode   = LX_IDLE;
        word_n = 0;
    endtask

    always @(posedge i_clk) begin
        t_lex_res got;
        t_lex_res want;
        if (!i_rst_n) begin
            mode    = LX_IDLE;
            dq_open = 1'b0;
            word_n  = 0;
            token_q.delete();
        end else begin
            // request side first: a result never leaves in the cycle its request enters
            if (i_in_valid && i_in_ready) begin
                step_n = 0;
                if (i_in_req == REQ_END) lex_end();
                else lex_byte(i_in_byte);
                if (step_n > 0) step_res[step_n-1].last = 1'b1;
                for (int i = 0; i < step_n; i++) token_q = {token_q, step_res[i]};
            end
            if (i_out_valid && i_out_ready) begin
                got.is_end = i_out_user[0];
                got.val    = i_out_byte;
                got.kind   = i_out_user[3:1];
                got.last   = i_out_last;
                if (token_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unpredicted result end=%0d val=%02h kind=%0d last=%0d",
                                 $realtime, got.is_end, got.val, got.kind, got.last);
                end else begin
                    want = token_q.pop_front();
                    if (got.is_end !== want.is_end || got.val !== want.val ||
                        got.kind !== want.kind || got.last !== want.last) begin
                        errs++;
                        if (errs <= 10) begin
                            $write("%0t: result %0d differs: expected end=%0d val=%02h ",
                                   $realtime, checked, want.is_end, want.val);
                            $display("kind=%0d last=%0d, got end=%0d val=%02h kind=%0d last=%0d",
                                     want.kind, want.last, got.is_end, got.val, got.kind,
                                     got.last);
                        end
                    end
                end
                checked++;
            end
        end
        o_errors  <= errs;
        o_pending <= token_q.size();
        o_checked <= checked;
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the query lexer: clock, reset, request stimulus, result stalls, verdict.
module tb import slu_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_REQS = 170;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // in_byte
    logic       s_axis_tuser = 1'b0;    // req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // value_byte
    logic [3:0] m_axis_tuser;           // is_token_end, token_kind[2:0]
    logic       m_axis_tlast;           // last_in_run

    int         errors;
    int         pending;
    int         checked;
    int         sent;
    int         burst_left;
    logic [7:0] stall_cyc = 8'd0;

    sql_query_lexer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    slu_token_checker u_lex_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_req    (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_byte  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver: the top two bits of the stall counter switch between always ready,
    // mostly ready, one cycle in three, and mostly stalled.
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 8'd1;
        case (stall_cyc[7:6])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= (stall_cyc % 3 == 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        #2_000_000;
        $display("sql_query_lexer_unit: mismatch");
        $finish;
    end

    task automatic send_req(input logic req, input logic [7:0] b);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        sent++;
    endtask

    task automatic send_word(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1))
                c = c ^ 8'h20;
            send_req(REQ_BYTE, c);
        end
    endtask

    // Hold requests back until every predicted result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    function automatic logic [7:0] pick_word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return "a" + 8'(r);
        if (r < 52) return "A" + 8'(r - 26);
        if (r == 52) return "_";
        return "0" + 8'(r - 53);
    endfunction

    initial begin
        string      word;
        logic [7:0] c;
        logic [7:0] q;
        int         ntok;
        int         queries;
        int         noise_runs;
        bit         paused;

        queries    = 0;
        noise_runs = 0;
        paused     = 1'b0;
        sent       = 0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Mixed-case SELECT closed by a star (largest burst of results), operators
        // with and without '=', a number cut by a comma, a double-quoted string
        // holding the other quote and a tab then cut by NUL, a high byte, and a
        // seven-byte identifier left open at end of input.
        send_word("SeLeCt* <=>9,\"'\t", 1'b0);
        send_req(REQ_BYTE, 8'h00);
        send_req(REQ_BYTE, 8'hFF);
        send_word("abcdefg", 1'b0);
        send_req(REQ_END, 8'hA5);
        wait_drained();

        while (sent < N_REQS) begin
            if ($urandom_range(0, 6) == 0) begin
                // noise: arbitrary bytes, sometimes closed
                repeat ($urandom_range(1, 6)) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) send_req(REQ_END, 8'($urandom_range(0, 255)));
                noise_runs++;
            end else begin
                ntok = $urandom_range(1, 6);
                for (int t = 0; t < ntok && sent < N_REQS; t++) begin
                    case ($urandom_range(0, 6))
                        0: begin
                            case ($urandom_range(0, 2))
                                0: word = "select";
                                1: word = "from";
                                default: word = "where";
                            endcase
                            send_word(word, 1'b1);
                        end
                        1: begin
                            // near misses stay identifiers
                            case ($urandom_range(0, 3))
                                0: word = "selec";
                                1: word = "fromage";
                                2: word = "where_1";
                                default: word = "SELECTED";
                            endcase
                            send_word(word, 1'b1);
                        end
                        2: begin
                            send_req(REQ_BYTE, pick_word_char(1'b1));
                            repeat ($urandom_range(0, 8)) send_req(REQ_BYTE, pick_word_char(1'b0));
                        end
                        3: repeat ($urandom_range(1, 4))
                            send_req(REQ_BYTE, "0" + 8'($urandom_range(0, 9)));
                        4: begin
                            q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                            send_req(REQ_BYTE, q);
                            repeat ($urandom_range(0, 5)) begin
                                c = 8'($urandom_range(1, 255));
                                if (c == q) c = q ^ 8'h05;   // swap to the other quote
                                send_req(REQ_BYTE, c);
                            end
                            case ($urandom_range(0, 9))
                                7: send_req(REQ_BYTE, 8'h00);
                                8, 9: ;                        // left open
                                default: send_req(REQ_BYTE, q);
                            endcase
                        end
                        5: begin
                            case ($urandom_range(0, 2))
                                0: send_req(REQ_BYTE, "=");
                                1: send_req(REQ_BYTE, "<");
                                default: send_req(REQ_BYTE, ">");
                            endcase
                            if ($urandom_range(0, 1)) send_req(REQ_BYTE, "=");
                        end
                        default: begin
                            case ($urandom_range(0, 3))
                                0: send_req(REQ_BYTE, ",");
                                1: send_req(REQ_BYTE, "*");
                                2: send_req(REQ_BYTE, 8'($urandom_range(128, 255)));
                                default: send_req(REQ_BYTE, ";");
                            endcase
                        end
                    endcase
                    if ($urandom_range(0, 2) != 0)
                        repeat ($urandom_range(1, 2)) send_req(REQ_BYTE, pick_blank());
                end
                send_req(REQ_END, 8'($urandom_range(0, 255)));
                queries++;
            end
            if (!paused && sent > 90) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Lexer run: %0d requests in %0d queries and %0d noise runs,", sent, queries,
                 noise_runs);
        $display("  %0d token results compared, %0d still outstanding.", checked, pending);
        if (errors == 0 && pending == 0) begin
            $display("sql_query_lexer_unit: match");
        end else begin
            $display("sql_query_lexer_unit: mismatch");
        end
        $finish;
    end

endmodule
